@@ rtl/rgb_raster_to_ascii_art_assert.svh @@
// Assertion macros used by the port-level checker of the raster to ASCII block
`ifndef RGB_RASTER_TO_ASCII_ART_ASSERT_SVH
`define RGB_RASTER_TO_ASCII_ART_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define RRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rra assertion failed");

// Next-cycle implication, disabled while reset is low
`define RRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rra assertion failed");

`endif

@@ rtl/rra_pkg.sv @@
// Shared types, constants and functions of the raster to ASCII block
package rra_pkg;

    // Register file geometry
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 13;
    localparam int ROWS_W     = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_OUT_ROWS     = 2'd2,
        CFG_REVERSE_RAMP = 2'd3
    } t_cfg_idx;

    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 13'd80;
    localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd1;
    localparam logic [ROWS_W-1:0]   RST_OUT_ROWS     = 12'd0;
    localparam logic                RST_REVERSE_RAMP = 1'b0;

    // Pixel and character payloads
    localparam int COLOR_W    = 8;
    localparam int CHAR_W     = 7;
    localparam int LUMA_SUM_W = 18;   // 299r+587g+114b peaks at 255000
    localparam int RAMP_LEN   = 10;
    localparam int RAMP_IDX_W = 4;

    typedef logic [COLOR_W-1:0]    t_color;
    typedef logic [CHAR_W-1:0]     t_char;
    typedef logic [LUMA_SUM_W-1:0] t_luma_sum;
    typedef logic [RAMP_IDX_W-1:0] t_ramp_idx;

    // Light-to-dark ramp " .:-=+*#&@"; the reversed ramp reads it backwards
    localparam t_char RAMP_FWD [RAMP_LEN] = '{
        7'h20, 7'h2E, 7'h3A, 7'h2D, 7'h3D, 7'h2B, 7'h2A, 7'h23, 7'h26, 7'h40
    };

    // Ramp step k is reached when luma >= ceil(255k/9), i.e. the weighted
    // sum reaches 1000 times that luma value
    localparam t_luma_sum SHADE_STEP [RAMP_LEN-1] = '{
        18'd29000, 18'd57000, 18'd85000, 18'd114000, 18'd142000,
        18'd170000, 18'd199000, 18'd227000, 18'd255000
    };

    // Per-transaction marks from the position tracker
    typedef struct packed {
        logic keep;
        logic eol;
        logic eof;
    } t_mark;

    // Weighted luma sum, scaled by 1000
    function automatic t_luma_sum luma_sum(input t_color r, input t_color g,
                                           input t_color b);
        luma_sum = LUMA_SUM_W'(r) * 18'd299 + LUMA_SUM_W'(g) * 18'd587
                 + LUMA_SUM_W'(b) * 18'd114;
    endfunction

    // Ramp index: number of shade steps that the sum reaches
    function automatic t_ramp_idx shade_index(input t_luma_sum sum);
        t_ramp_idx cnt;
        cnt = '0;
        for (int k = 0; k < RAMP_LEN - 1; k++) begin
            if (sum >= SHADE_STEP[k]) begin
                cnt = cnt + 1'b1;
            end
        end
        shade_index = cnt;
    endfunction

    // Character lookup, normal or reversed ramp
    function automatic t_char ramp_char(input t_ramp_idx idx, input logic rev);
        t_ramp_idx pos;
        pos = rev ? (RAMP_IDX_W'(RAMP_LEN - 1) - idx) : idx;
        ramp_char = RAMP_FWD[pos];
    endfunction

endpackage

@@ rtl/rra_pix_if.sv @@
// Pixel channel: valid/ready handshake with RGB24 payload and frame start mark
interface rra_pix_if;
    import rra_pkg::*;

    logic   valid;
    logic   ready;
    t_color red;
    t_color green;
    t_color blue;
    logic   start_of_frame;

    modport source (output valid, output red, output green, output blue,
                    output start_of_frame, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input start_of_frame, output ready);
endinterface

@@ rtl/rra_chr_if.sv @@
// Character channel: valid/ready handshake with ASCII code and line/frame marks
interface rra_chr_if;
    import rra_pkg::*;

    logic  valid;
    logic  ready;
    t_char char_code;
    logic  end_of_line;
    logic  end_of_frame;

    modport source (output valid, output char_code, output end_of_line,
                    output end_of_frame, input ready);
    modport sink   (input valid, input char_code, input end_of_line,
                    input end_of_frame, output ready);
endinterface

@@ rtl/rra_tracker.sv @@
// Source/output position tracking and nearest-neighbour sample selection
module rra_tracker #(
    parameter int OUT_COLS = 80,
    parameter int MAX_DIM  = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_sof,
    input  logic [rra_pkg::WIDTH_W-1:0]   i_cfg_width,
    input  logic [rra_pkg::HEIGHT_W-1:0]  i_cfg_height,
    input  logic [rra_pkg::ROWS_W-1:0]    i_cfg_rows,
    output rra_pkg::t_mark                o_mark
);
    import rra_pkg::*;

    localparam int SRC_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int OCOL_W = $clog2(OUT_COLS + 1);
    localparam int CACC_W = $clog2(OUT_COLS * MAX_DIM + 1);
    localparam int RACC_W = $clog2(MAX_DIM * MAX_DIM + 1);

    logic [SRC_W-1:0]  r_src_col, n_src_col, c_src_col;
    logic [SRC_W-1:0]  r_src_row, n_src_row, c_src_row;
    logic [CACC_W-1:0] r_col_scaled, n_col_scaled, c_col_scaled;
    logic [CACC_W-1:0] r_col_target, n_col_target, c_col_target;
    logic [OCOL_W-1:0] r_out_col, n_out_col, c_out_col;
    logic [RACC_W-1:0] r_row_scaled, n_row_scaled, c_row_scaled;
    logic [RACC_W-1:0] r_row_target, n_row_target, c_row_target;
    logic [DIM_W-1:0]  r_out_row, n_out_row, c_out_row;

    logic [31:0]      w32, h32, rows32;
    logic [DIM_W-1:0] w, h, rows;
    logic             row_kept, col_kept, eol;

    // Effective geometry after clamping the registers
    always_comb begin
        w32 = 32'(i_cfg_width);
        if (w32 < 32'(OUT_COLS)) begin
            w32 = 32'(OUT_COLS);
        end
        if (w32 > 32'(MAX_DIM)) begin
            w32 = 32'(MAX_DIM);
        end
        h32 = 32'(i_cfg_height);
        if (h32 < 32'd1) begin
            h32 = 32'd1;
        end
        if (h32 > 32'(MAX_DIM)) begin
            h32 = 32'(MAX_DIM);
        end
        rows32 = 32'(i_cfg_rows);
        if (rows32 > h32) begin
            rows32 = h32;
        end
        w    = DIM_W'(w32);
        h    = DIM_W'(h32);
        rows = DIM_W'(rows32);
    end

    // Frame start clears the position before the pixel is looked at
    always_comb begin
        c_src_col    = i_sof ? '0 : r_src_col;
        c_src_row    = i_sof ? '0 : r_src_row;
        c_col_scaled = i_sof ? '0 : r_col_scaled;
        c_col_target = i_sof ? '0 : r_col_target;
        c_out_col    = i_sof ? '0 : r_out_col;
        c_row_scaled = i_sof ? '0 : r_row_scaled;
        c_row_target = i_sof ? '0 : r_row_target;
        c_out_row    = i_sof ? '0 : r_out_row;
    end

    // Sample test: target position has been reached in this row and column
    always_comb begin
        row_kept = (c_out_row < rows)
                && ((RACC_W+1)'(c_row_target) < (RACC_W+1)'(c_row_scaled)
                                              + (RACC_W+1)'(rows));
        col_kept = (c_out_col < OCOL_W'(OUT_COLS))
                && ((CACC_W+1)'(c_col_target) < (CACC_W+1)'(c_col_scaled)
                                              + (CACC_W+1)'(OUT_COLS));
        eol = (c_out_col == OCOL_W'(OUT_COLS - 1));
        o_mark.keep = row_kept && col_kept;
        o_mark.eol  = eol;
        o_mark.eof  = eol && (c_out_row == rows - DIM_W'(1));
    end

    // Position update for the accepted pixel
    always_comb begin
        n_src_col    = c_src_col;
        n_src_row    = c_src_row;
        n_col_scaled = c_col_scaled;
        n_col_target = c_col_target;
        n_out_col    = c_out_col;
        n_row_scaled = c_row_scaled;
        n_row_target = c_row_target;
        n_out_row    = c_out_row;
        if (o_mark.keep) begin
            n_out_col    = c_out_col + OCOL_W'(1);
            n_col_target = c_col_target + CACC_W'(w);
        end
        if (DIM_W'(c_src_col) >= w - DIM_W'(1)) begin
            // end of source row
            if (row_kept) begin
                n_out_row    = c_out_row + DIM_W'(1);
                n_row_target = c_row_target + RACC_W'(h);
            end
            n_src_col    = '0;
            n_col_scaled = '0;
            n_col_target = '0;
            n_out_col    = '0;
            if (DIM_W'(c_src_row) >= h - DIM_W'(1)) begin
                // end of frame: wrap to the start of the next one
                n_src_row    = '0;
                n_row_scaled = '0;
                n_row_target = '0;
                n_out_row    = '0;
            end else begin
                n_src_row    = c_src_row + SRC_W'(1);
                n_row_scaled = c_row_scaled + RACC_W'(rows);
            end
        end else begin
            n_src_col    = c_src_col + SRC_W'(1);
            n_col_scaled = c_col_scaled + CACC_W'(OUT_COLS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col    <= '0;
            r_src_row    <= '0;
            r_col_scaled <= '0;
            r_col_target <= '0;
            r_out_col    <= '0;
            r_row_scaled <= '0;
            r_row_target <= '0;
            r_out_row    <= '0;
        end else if (i_accept) begin
            r_src_col    <= n_src_col;
            r_src_row    <= n_src_row;
            r_col_scaled <= n_col_scaled;
            r_col_target <= n_col_target;
            r_out_col    <= n_out_col;
            r_row_scaled <= n_row_scaled;
            r_row_target <= n_row_target;
            r_out_row    <= n_out_row;
        end
    end

endmodule

@@ rtl/rra_shade.sv @@
// Two-stage luma and ramp lookup pipeline with output register
module rra_shade (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rra_pkg::t_color       i_red,
    input  rra_pkg::t_color       i_green,
    input  rra_pkg::t_color       i_blue,
    input  logic                  i_eol,
    input  logic                  i_eof,
    input  logic                  i_reverse,
    input  logic                  i_out_ready,
    output logic                  o_in_ready,
    output logic                  o_valid,
    output rra_pkg::t_char        o_char,
    output logic                  o_eol,
    output logic                  o_eof
);
    import rra_pkg::*;

    logic      r_a_valid;
    t_luma_sum r_a_sum;
    logic      r_a_eol, r_a_eof;
    logic      r_b_valid;
    t_char     r_b_char;
    logic      r_b_eol, r_b_eof;
    logic      b_take;
    t_char     n_b_char;

    // Each stage moves when the stage after it has room
    assign b_take     = !r_b_valid || i_out_ready;
    assign o_in_ready = !r_a_valid || b_take;

    // Stage A: weighted luma sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_push;
        end
        if (o_in_ready && i_push) begin
            r_a_sum <= luma_sum(i_red, i_green, i_blue);
            r_a_eol <= i_eol;
            r_a_eof <= i_eof;
        end
    end

    // Stage B: ramp index and character into the output register
    assign n_b_char = ramp_char(shade_index(r_a_sum), i_reverse);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_take) begin
            r_b_valid <= r_a_valid;
        end
        if (b_take && r_a_valid) begin
            r_b_char <= n_b_char;
            r_b_eol  <= r_a_eol;
            r_b_eof  <= r_a_eof;
        end
    end

    assign o_valid = r_b_valid;
    assign o_char  = r_b_char;
    assign o_eol   = r_b_eol;
    assign o_eof   = r_b_eof;

endmodule

@@ rtl/rgb_raster_to_ascii_art.sv @@
// Top level: RGB raster pixels in, nearest-neighbour ASCII art characters out
//
// i_pix carries RGB24 pixels in raster order; start_of_frame marks the first
// pixel of a frame. Every pixel is a transaction, but only the pixels on the
// sampling grid (OUT_COLS columns by out_rows rows) produce a character on
// o_chr, tagged with end_of_line and end_of_frame.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data:
// image_width, image_height, out_rows, reverse_ramp. The user is to write it
// only while the block is idle; the block itself does not enforce this.
// A character passes the luma sum register and then the output register.
// Throughput: one pixel per clock while i_pix.ready is high; the position
// update of the tracker is a combinational accumulate and compare per pixel.
// Reset (synchronous) restores the register defaults, clears the position to
// column 0 of row 0 and empties the pipeline.
// When o_chr stalls, the two stages fill up and i_pix.ready drops only once
// both hold a character; pixels that give no character still need ready.
module rgb_raster_to_ascii_art #(
    parameter int OUT_COLS = 80,
    parameter int MAX_DIM  = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  rra_pkg::t_cfg_idx                i_cfg_index,
    input  logic [rra_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rra_pix_if.sink                          i_pix,
    rra_chr_if.source                        o_chr
);
    import rra_pkg::*;

    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    logic [ROWS_W-1:0]   r_out_rows;
    logic                r_reverse_ramp;
    logic                accept;
    logic                in_ready;
    t_mark               mark;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_out_rows     <= RST_OUT_ROWS;
            r_reverse_ramp <= RST_REVERSE_RAMP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[WIDTH_W-1:0];
                end
                CFG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data[HEIGHT_W-1:0];
                end
                CFG_OUT_ROWS: begin
                    r_out_rows <= i_cfg_data[ROWS_W-1:0];
                end
                CFG_REVERSE_RAMP: begin
                    r_reverse_ramp <= i_cfg_data[0];
                end
            endcase
        end
    end

    assign accept      = i_pix.valid && in_ready;
    assign i_pix.ready = in_ready;

    rra_tracker #(
        .OUT_COLS (OUT_COLS),
        .MAX_DIM  (MAX_DIM)
    ) u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_sof        (i_pix.start_of_frame),
        .i_cfg_width  (r_image_width),
        .i_cfg_height (r_image_height),
        .i_cfg_rows   (r_out_rows),
        .o_mark       (mark)
    );

    rra_shade u_shade (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept && mark.keep),
        .i_red       (i_pix.red),
        .i_green     (i_pix.green),
        .i_blue      (i_pix.blue),
        .i_eol       (mark.eol),
        .i_eof       (mark.eof),
        .i_reverse   (r_reverse_ramp),
        .i_out_ready (o_chr.ready),
        .o_in_ready  (in_ready),
        .o_valid     (o_chr.valid),
        .o_char      (o_chr.char_code),
        .o_eol       (o_chr.end_of_line),
        .o_eof       (o_chr.end_of_frame)
    );

endmodule

@@ rtl/rra_checker.sv @@
// Port-level checker for the raster to ASCII block, with its bind statement
`include "rgb_raster_to_ascii_art_assert.svh"

module rra_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input rra_pkg::t_char        i_char_code,
    input logic                  i_end_of_line,
    input logic                  i_end_of_frame
);
    import rra_pkg::*;

    // A stalled character stays offered
    `RRA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // A stalled character keeps its payload
    `RRA_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_char_code) && $stable(i_end_of_line) && $stable(i_end_of_frame))

    // Frame end always closes a row
    `RRA_ASSERT_IMP(a_eof_is_eol, i_clk, i_rst_n, i_out_valid && i_end_of_frame, i_end_of_line)

    // Only ramp characters leave the block
    `RRA_ASSERT_IMP(a_char_in_ramp, i_clk, i_rst_n, i_out_valid, i_char_code == RAMP_FWD[0] || i_char_code == RAMP_FWD[1] || i_char_code == RAMP_FWD[2] || i_char_code == RAMP_FWD[3] || i_char_code == RAMP_FWD[4] || i_char_code == RAMP_FWD[5] || i_char_code == RAMP_FWD[6] || i_char_code == RAMP_FWD[7] || i_char_code == RAMP_FWD[8] || i_char_code == RAMP_FWD[9])

endmodule

bind rgb_raster_to_ascii_art rra_checker u_rra_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_chr.valid),
    .i_out_ready    (o_chr.ready),
    .i_char_code    (o_chr.char_code),
    .i_end_of_line  (o_chr.end_of_line),
    .i_end_of_frame (o_chr.end_of_frame)
);

@@ dv/rra_char_checker.sv @@
// Checker for the raster to ASCII block: predicts the character stream and compares it
module rra_char_checker
    import rra_pkg::*;
#(
    parameter int OUT_COLS = 80,
    parameter int MAX_DIM  = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rra_pix_if                    pix,
    rra_chr_if                    chr,
    output int                    o_pending,
    output int                    o_fails,
    output int                    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_char code;
        logic  eol;
        logic  eof;
    } t_glyph;

    // Light-to-dark shade ramp " .:-=+*#&@"; the reversed ramp is read from the far end
    localparam logic [7:0] GLYPHS [10] = '{
        8'h20, 8'h2E, 8'h3A, 8'h2D, 8'h3D, 8'h2B, 8'h2A, 8'h23, 8'h26, 8'h40
    };

    // Shadow copy of the registers
    logic [WIDTH_W-1:0]  width_q;
    logic [HEIGHT_W-1:0] height_q;
    logic [ROWS_W-1:0]   rows_q;
    logic                rev_q;

    // Raster position and sampling accumulators
    logic [31:0] col_pos, row_pos;
    logic [31:0] col_sum, col_goal, chars_in_line;
    logic [31:0] row_sum, row_goal, lines_done;

    t_glyph glyph_q [$];
    int     fails   = 0;
    int     checked = 0;

    task automatic restart_line();
        col_pos       = '0;
        col_sum       = '0;
        col_goal      = '0;
        chars_in_line = '0;
    endtask

    task automatic restart_frame();
        restart_line();
        row_pos    = '0;
        row_sum    = '0;
        row_goal   = '0;
        lines_done = '0;
    endtask

    // One pixel transaction: queue the character it yields, then step the raster
    task automatic render_pixel(input t_color r, input t_color g, input t_color b,
                                input logic sof);
        logic [31:0] w, h, rows, luma, shade;
        logic        line_kept;
        t_glyph      e;
        if (sof) begin
            restart_frame();
        end
        w = 32'(width_q);
        if (w < OUT_COLS) w = OUT_COLS;
        if (w > MAX_DIM) w = MAX_DIM;
        h = 32'(height_q);
        if (h < 1) h = 1;
        if (h > MAX_DIM) h = MAX_DIM;
        rows = 32'(rows_q);
        if (rows > h) rows = h;

        line_kept = (lines_done < rows) && (row_goal < row_sum + rows);

        if (line_kept && chars_in_line < OUT_COLS && col_goal < col_sum + OUT_COLS) begin
            luma  = (32'd299 * r + 32'd587 * g + 32'd114 * b) / 32'd1000;
            shade = luma * 32'd9 / 32'd255;
            if (shade > 9) shade = 9;
            e.code = t_char'(rev_q ? GLYPHS[9 - shade] : GLYPHS[shade]);
            e.eol  = (chars_in_line == OUT_COLS - 1);
            e.eof  = e.eol && (lines_done == rows - 1);
            glyph_q = {glyph_q, e};
            chars_in_line = chars_in_line + 1;
            col_goal      = col_goal + w;
        end

        if (col_pos >= w - 1) begin
            if (line_kept) begin
                lines_done = lines_done + 1;
                row_goal   = row_goal + h;
            end
            restart_line();
            if (row_pos >= h - 1) begin
                restart_frame();
            end else begin
                row_pos = row_pos + 1;
                row_sum = row_sum + rows;
            end
        end else begin
            col_pos = col_pos + 1;
            col_sum = col_sum + OUT_COLS;
        end
    endtask

    always @(posedge i_clk) begin
        t_glyph want;
        if (!i_rst_n) begin
            width_q  = RST_IMAGE_WIDTH;
            height_q = RST_IMAGE_HEIGHT;
            rows_q   = RST_OUT_ROWS;
            rev_q    = RST_REVERSE_RAMP;
            restart_frame();
            glyph_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  width_q  = i_cfg_data[WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: height_q = i_cfg_data[HEIGHT_W-1:0];
                    CFG_OUT_ROWS:     rows_q   = i_cfg_data[ROWS_W-1:0];
                    CFG_REVERSE_RAMP: rev_q    = i_cfg_data[0];
                    default: ;
                endcase
            end

            // Character transaction against the oldest prediction
            if (chr.valid && chr.ready) begin
                if (glyph_q.size() == 0) begin
                    $error("char_code: nothing expected, actual %h", chr.char_code);
                    fails++;
                end else begin
                    want = glyph_q.pop_front();
                    checked++;
                    if (chr.char_code !== want.code) begin
                        $error("char_code: expected %h, actual %h", want.code, chr.char_code);
                        fails++;
                    end
                    if (chr.end_of_line !== want.eol) begin
                        $error("end_of_line: expected %b, actual %b", want.eol,
                               chr.end_of_line);
                        fails++;
                    end
                    if (chr.end_of_frame !== want.eof) begin
                        $error("end_of_frame: expected %b, actual %b", want.eof,
                               chr.end_of_frame);
                        fails++;
                    end
                end
            end

            if (pix.valid && pix.ready) begin
                render_pixel(pix.red, pix.green, pix.blue, pix.start_of_frame);
            end
        end
        o_pending <= glyph_q.size();
        o_fails   <= fails;
        o_checked <= checked;
    end

endmodule

@@ dv/tb.sv @@
// Testbench top: clock, reset, register writes, pixel stimulus and the verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rra_pkg::*;

    localparam int OUT_COLS = 80;
    localparam int MAX_DIM  = 4096;

    localparam logic [23:0] PRIMARIES [5] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int pending, fails, checked;
    bit idle_on    = 1'b1;
    int quiet_left = 0;
    int stall_left = 0;
    int frame_px   = 1;
    int frame_pos  = 0;
    int n_settings = 0;
    int n_sent     = 0;

    rra_pix_if pix ();
    rra_chr_if chr ();

    rgb_raster_to_ascii_art #(
        .OUT_COLS (OUT_COLS),
        .MAX_DIM  (MAX_DIM)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix       (pix),
        .o_chr       (chr)
    );

    rra_char_checker #(
        .OUT_COLS (OUT_COLS),
        .MAX_DIM  (MAX_DIM)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .pix         (pix),
        .chr         (chr),
        .o_pending   (pending),
        .o_fails     (fails),
        .o_checked   (checked)
    );

    always #1 i_clk = ~i_clk;

    // Character sink: random stall bursts, with calm stretches in between
    always @(posedge i_clk) begin
        if (quiet_left != 0) begin
            quiet_left <= quiet_left - 1;
        end else if ($urandom_range(0, 99) == 0) begin
            quiet_left <= $urandom_range(40, 160);
        end
        if (stall_left != 0) begin
            chr.ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && quiet_left == 0 && $urandom_range(0, 3) == 0) begin
            chr.ready  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            chr.ready <= 1'b1;
        end
    end

    function automatic int clamp_dim(input int v, input int lo);
        return (v < lo) ? lo : ((v > MAX_DIM) ? MAX_DIM : v);
    endfunction

    // Pixel colors: uniform, grays on both sides of a shade step, saturated, one channel
    function automatic logic [23:0] pick_color();
        logic [7:0]  g;
        logic [31:0] m;
        int          k;
        case ($urandom_range(0, 9))
            0, 1: begin
                k = $urandom_range(1, 9);
                g = 8'((255 * k + 8) / 9 - $urandom_range(0, 1));
                return {3{g}};
            end
            2: begin
                m = $urandom;
                return {m[0] ? 8'hFF : 8'h00, m[1] ? 8'hFF : 8'h00, m[2] ? 8'hFF : 8'h00};
            end
            3: return 24'($urandom_range(0, 255)) << (8 * $urandom_range(0, 2));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic write_regs(input int w, input int h, input int r, input bit rev);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge i_clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h);
        @(posedge i_clk);
        cfg_index <= CFG_OUT_ROWS;
        cfg_data  <= CFG_DATA_W'(r);
        @(posedge i_clk);
        cfg_index <= CFG_REVERSE_RAMP;
        cfg_data  <= CFG_DATA_W'(rev);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        frame_px = clamp_dim(w, OUT_COLS) * clamp_dim(h, 1);
        n_settings++;
    endtask

    // One pixel transaction, with an occasional gap in front of it
    task automatic send_pixel(input logic [23:0] rgb, input logic sof);
        if (idle_on && quiet_left == 0 && $urandom_range(0, 4) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        {pix.red, pix.green, pix.blue} <= rgb;
        pix.start_of_frame <= sof;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        n_sent++;
    endtask

    // Mostly well-formed frames; some frames wrap on their own, a few restart early
    task automatic stream_pixels(input int count, input bit fresh);
        logic sof;
        if (fresh) frame_pos = 0;
        for (int i = 0; i < count; i++) begin
            sof = (fresh && i == 0) || (frame_pos == 0 && $urandom_range(0, 3) != 0)
                || ($urandom_range(0, 199) == 0);
            if (sof) frame_pos = 0;
            send_pixel(pick_color(), sof);
            frame_pos = (frame_pos + 1) % frame_px;
        end
    endtask

    // Wait until every predicted character is out and the pipeline is empty
    task automatic drain();
        pix.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        pix.valid          = 1'b0;
        pix.red            = '0;
        pix.green          = '0;
        pix.blue           = '0;
        pix.start_of_frame = 1'b0;
        chr.ready          = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_IMAGE_WIDTH;
        cfg_data           = '0;
        i_rst_n            = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: primaries and grays straddling every shade step, one output row
        write_regs(80, 2, 1, 1'b0);
        for (int i = 0; i < 5; i++) begin
            send_pixel(PRIMARIES[i], i == 0);
        end
        for (int k = 1; k <= 9; k++) begin
            send_pixel({3{8'((255 * k + 8) / 9 - 1)}}, 1'b0);
            send_pixel({3{8'((255 * k + 8) / 9)}}, 1'b0);
        end
        frame_pos = 23;
        stream_pixels(137, 1'b0);
        drain();

        // Width below minimum, every source row kept, reversed ramp
        write_regs(0, 3, 3, 1'b1);
        stream_pixels(240, 1'b1);
        drain();

        write_regs(100, 3, 2, 1'b0);
        stream_pixels(240, 1'b1);
        drain();

        // Oversized width, zero height, row count above height
        write_regs(8191, 0, 2048, 1'b1);
        stream_pixels(150, 1'b1);
        drain();

        // Size shrinks mid-frame: the current column is already past the new width
        write_regs(81, 2, 5, 1'b0);
        stream_pixels(250, 1'b0);
        drain();

        // No output rows at all
        write_regs(80, 1, 0, 1'b1);
        stream_pixels(80, 1'b1);
        drain();

        write_regs(160, 2, 1, 1'b1);
        stream_pixels(240, 1'b1);
        drain();

        // Largest legal image, only the start of its first row
        write_regs(MAX_DIM, MAX_DIM, 2048, 1'b0);
        stream_pixels(100, 1'b1);
        drain();

        // Closing stretch at full rate on both sides
        idle_on = 1'b0;
        write_regs(79, 4, 2, 1'b0);
        stream_pixels(240, 1'b1);
        drain();

        $display("Sent %0d pixels over %0d register settings, compared %0d characters.",
                 n_sent, n_settings, checked);
        $display("Both ramps, clamped sizes, frame wrap and mid-frame resizing were hit.");
        if (fails == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #500_000;
        $display("tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rra_pkg.sv
rtl/rra_pix_if.sv
rtl/rra_chr_if.sv
rtl/rra_tracker.sv
rtl/rra_shade.sv
rtl/rgb_raster_to_ascii_art.sv
rtl/rra_checker.sv
dv/rra_char_checker.sv
dv/tb.sv
